// ===== sv/cld_pkg.sv =====
`default_nettype none

package cld_pkg;

    // Operation codes carried by an input beat.
    localparam logic [1:0] OP_RX_BYTE     = 2'd0;
    localparam logic [1:0] OP_GET         = 2'd1;
    localparam logic [1:0] OP_CLEAR_READY = 2'd2;
    localparam logic [1:0] OP_NOP         = 2'd3;

    // Frame status codes reported with each result beat.
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // Camera modes.
    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_YPJ      = 3'd1;
    localparam logic [2:0] MODE_JT       = 3'd2;
    localparam logic [2:0] MODE_LZ       = 3'd3;
    localparam logic [2:0] MODE_LZ_WHITE = 3'd4;

    localparam logic [7:0] SITE_MAX = 8'd1;

    // Frame type bytes.
    localparam logic [7:0] DT_MODE_ACK = 8'h50;
    localparam logic [7:0] DT_51       = 8'h51;
    localparam logic [7:0] DT_52       = 8'h52;
    localparam logic [7:0] DT_53       = 8'h53;
    localparam logic [7:0] DT_54       = 8'h54;
    localparam logic [7:0] DT_55       = 8'h55;
    localparam logic [7:0] DT_56       = 8'h56;

    // The byte count saturates one above the longest stored frame.
    localparam int          FRAME_MAX   = 4;
    localparam logic [2:0]  COUNT_SHORT = 3'd1;
    localparam logic [2:0]  COUNT_LONG  = 3'(FRAME_MAX);
    localparam logic [2:0]  COUNT_SAT   = 3'(FRAME_MAX + 1);

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
        logic       frame_end;
        logic [2:0] query_mode;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]        frame_status;
        logic              get_hit;
        logic [7:0]        data_type;
        logic signed [7:0] data_x;
        logic signed [7:0] data_y;
        logic [2:0]        reported_mode;
        logic              reported_site;
        logic              data_ready;
        logic [31:0]       error_count;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== sv/cld_core.sv =====
`default_nettype none

module cld_core import cld_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_accept,
    input  t_in_beat   i_beat,
    output t_out_beat  o_result
);

    logic [7:0]  r_bytes [FRAME_MAX];
    logic [2:0]  r_count;
    logic [7:0]  r_type;
    logic [7:0]  r_x;
    logic [7:0]  r_y;
    logic [2:0]  r_mode;
    logic        r_site;
    logic        r_ready;
    logic [31:0] r_errors;

    logic [7:0]  n_bytes [FRAME_MAX];
    logic [2:0]  n_count;
    logic [7:0]  n_type;
    logic [7:0]  n_x;
    logic [7:0]  n_y;
    logic [2:0]  n_mode;
    logic        n_site;
    logic        n_ready;
    logic [31:0] n_errors;

    logic [2:0]  len;
    logic [7:0]  sum;
    logic        good;
    logic [1:0]  status;
    logic        hit;
    logic        match;

    always_comb begin
        unique case (i_beat.query_mode)
            MODE_YPJ:      match = (r_type == DT_51) || (r_type == DT_52);
            MODE_JT:       match = (r_type == DT_53) || (r_type == DT_54);
            MODE_LZ:       match = (r_type == DT_55);
            MODE_LZ_WHITE: match = (r_type == DT_56);
            default:       match = 1'b0;
        endcase
    end

    always_comb begin
        n_bytes  = r_bytes;
        n_count  = r_count;
        n_type   = r_type;
        n_x      = r_x;
        n_y      = r_y;
        n_mode   = r_mode;
        n_site   = r_site;
        n_ready  = r_ready;
        n_errors = r_errors;
        status   = ST_NONE;
        hit      = 1'b0;
        good     = 1'b0;

        if (r_count < COUNT_LONG) begin
            n_bytes[r_count[1:0]] = i_beat.rx_byte;
        end
        len = (r_count < COUNT_SAT) ? r_count + 3'd1 : r_count;
        // The frame is decoded with the byte of this beat already in place.
        sum = n_bytes[0] + n_bytes[1] + n_bytes[2];

        unique case (i_beat.operation)
            OP_RX_BYTE: begin
                n_count = len;
                if (i_beat.frame_end) begin
                    n_count = 3'd0;
                    if (len == COUNT_SHORT) begin
                        if ((n_bytes[0] == DT_51) || (n_bytes[0] == DT_52)
                                || (n_bytes[0] == DT_55)) begin
                            good   = 1'b1;
                            n_type = n_bytes[0];
                        end
                    end else if (len == COUNT_LONG && n_bytes[3] == sum) begin
                        if (n_bytes[0] == DT_MODE_ACK) begin
                            if (n_bytes[1] <= 8'(MODE_LZ_WHITE)
                                    && n_bytes[2] <= SITE_MAX) begin
                                good   = 1'b1;
                                n_mode = n_bytes[1][2:0];
                                n_site = n_bytes[2][0];
                            end
                        end else if (n_bytes[0] >= DT_53 && n_bytes[0] <= DT_56) begin
                            good   = 1'b1;
                            n_type = n_bytes[0];
                            n_x    = n_bytes[1];
                            n_y    = n_bytes[2];
                        end
                    end
                    if (good) begin
                        n_ready = 1'b1;
                        status  = ST_ACCEPT;
                    end else begin
                        n_errors = r_errors + 32'd1;
                        status   = ST_REJECT;
                    end
                end else begin
                    n_bytes = n_bytes;
                end
            end
            OP_GET: begin
                n_bytes = r_bytes;
                hit     = r_ready && match;
                n_ready = 1'b0;
            end
            OP_CLEAR_READY: begin
                n_bytes = r_bytes;
                n_ready = 1'b0;
            end
            OP_NOP: begin
                n_bytes = r_bytes;
            end
            default: begin
                n_bytes = r_bytes;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 3'd0;
            r_type   <= 8'd0;
            r_x      <= 8'd0;
            r_y      <= 8'd0;
            r_mode   <= MODE_IDLE;
            r_site   <= 1'b0;
            r_ready  <= 1'b0;
            r_errors <= 32'd0;
        end else if (i_accept) begin
            r_count  <= n_count;
            r_type   <= n_type;
            r_x      <= n_x;
            r_y      <= n_y;
            r_mode   <= n_mode;
            r_site   <= n_site;
            r_ready  <= n_ready;
            r_errors <= n_errors;
        end
    end

    // Frame bytes hold no reset value; decoding reads only bytes of the current frame.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_bytes <= n_bytes;
        end
    end

    always_comb begin
        o_result.frame_status  = status;
        o_result.get_hit       = hit;
        o_result.data_type     = n_type;
        o_result.data_x        = signed'(n_x);
        o_result.data_y        = signed'(n_y);
        o_result.reported_mode = n_mode;
        o_result.reported_site = n_site;
        o_result.data_ready    = n_ready;
        o_result.error_count   = n_errors;
    end

endmodule

`default_nettype wire

// ===== sv/camera_link_frame_decoder.sv =====
`default_nettype none

// Camera link frame decoder. Each input beat is a received byte (with a flag on
// the last byte of a frame), a get request for a mode, a ready-flag clear or a
// no-op, and each one yields exactly one result beat with the decoded state
// after it. The block takes one beat per clock while the input is not stalled:
// the frame decode is combinational compare and add logic that updates the
// state registers at the accepting edge, and the result is registered into a
// two-entry output buffer. The input stalls only while both buffer entries are
// full, so a waiting result does not hold up the next input beat.
module camera_link_frame_decoder import cld_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_in_beat   i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out_beat  o_out_data
);

    t_out_beat   result;
    t_out_beat   r_buf [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_fill;
    logic        in_acc;
    logic        out_pop;

    assign o_in_stall  = (r_fill == 2'd2);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_fill != 2'd0);
    assign out_pop     = o_out_valid && !i_out_stall;
    assign o_out_data  = r_buf[r_rd_ptr];

    cld_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_beat   (i_in_data),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (in_acc) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (out_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (in_acc && !out_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (out_pop && !in_acc) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_buf[r_wr_ptr] <= result;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'd2)
        else $error("output buffer fill exceeds two entries");

    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !out_pop) |=> (r_fill == $past(r_fill) + 2'd1))
        else $error("accepted beat without a pop did not grow the buffer");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 2'd0 || r_fill == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("buffer pointers disagree with the fill count");

endmodule

`default_nettype wire

// ===== tb/sv/camera_link_frame_decoder_tb.sv =====
module camera_link_frame_decoder_tb;
    import cld_pkg::*;

    // Mirror of the decoder state. It predicts one result beat for every
    // accepted input beat and checks result beats in order.
    class link_decoder_mirror;
        logic [7:0]  frame_buf [4];
        logic [2:0]  byte_cnt;
        logic [7:0]  kept_type;
        logic [7:0]  kept_x;
        logic [7:0]  kept_y;
        logic [2:0]  ack_mode;
        logic        ack_site;
        logic        ready;
        logic [31:0] rejects;
        t_out_beat   awaited [$];
        int          mismatches;
        int          results_seen;
        int          frames_ok;
        int          frames_bad;
        int          hits;

        function new();
            foreach (frame_buf[i]) frame_buf[i] = '0;
            byte_cnt     = '0;
            kept_type    = '0;
            kept_x       = '0;
            kept_y       = '0;
            ack_mode     = MODE_IDLE;
            ack_site     = 1'b0;
            ready        = 1'b0;
            rejects      = '0;
            mismatches   = 0;
            results_seen = 0;
            frames_ok    = 0;
            frames_bad   = 0;
            hits         = 0;
        endfunction

        function bit decode_frame(logic [2:0] len);
            logic [7:0] sum;
            if (len == COUNT_SHORT) begin
                if (frame_buf[0] != DT_51 && frame_buf[0] != DT_52 && frame_buf[0] != DT_55)
                    return 1'b0;
                kept_type = frame_buf[0];
                return 1'b1;
            end
            if (len == COUNT_LONG) begin
                sum = frame_buf[0] + frame_buf[1] + frame_buf[2];
                if (frame_buf[3] != sum)
                    return 1'b0;
                case (frame_buf[0])
                    DT_MODE_ACK: begin
                        if (frame_buf[1] > 8'(MODE_LZ_WHITE) || frame_buf[2] > SITE_MAX)
                            return 1'b0;
                        ack_mode = frame_buf[1][2:0];
                        ack_site = frame_buf[2][0];
                        return 1'b1;
                    end
                    DT_53, DT_54, DT_55, DT_56: begin
                        kept_type = frame_buf[0];
                        kept_x    = frame_buf[1];
                        kept_y    = frame_buf[2];
                        return 1'b1;
                    end
                    default: return 1'b0;
                endcase
            end
            return 1'b0;
        endfunction

        function bit type_wanted(logic [2:0] mode);
            case (mode)
                MODE_YPJ:      return kept_type == DT_51 || kept_type == DT_52;
                MODE_JT:       return kept_type == DT_53 || kept_type == DT_54;
                MODE_LZ:       return kept_type == DT_55;
                MODE_LZ_WHITE: return kept_type == DT_56;
                default:       return 1'b0;
            endcase
        endfunction

        function void take_input(t_in_beat b);
            t_out_beat r;
            r = '0;
            r.frame_status = ST_NONE;
            case (b.operation)
                OP_RX_BYTE: begin
                    if (byte_cnt < COUNT_LONG)
                        frame_buf[byte_cnt[1:0]] = b.rx_byte;
                    if (byte_cnt < COUNT_SAT)
                        byte_cnt = byte_cnt + 3'd1;
                    if (b.frame_end) begin
                        if (decode_frame(byte_cnt)) begin
                            ready = 1'b1;
                            r.frame_status = ST_ACCEPT;
                            frames_ok++;
                        end else begin
                            rejects = rejects + 32'd1;
                            r.frame_status = ST_REJECT;
                            frames_bad++;
                        end
                        byte_cnt = '0;
                    end
                end
                OP_GET: begin
                    r.get_hit = ready && type_wanted(b.query_mode);
                    ready = 1'b0;
                    if (r.get_hit) hits++;
                end
                OP_CLEAR_READY: ready = 1'b0;
                default: ;
            endcase
            r.data_type     = kept_type;
            r.data_x        = kept_x;
            r.data_y        = kept_y;
            r.reported_mode = ack_mode;
            r.reported_site = ack_site;
            r.data_ready    = ready;
            r.error_count   = rejects;
            awaited.push_back(r);
        endfunction

        task note_mismatch(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        task compare_output(t_out_beat got);
            t_out_beat want;
            results_seen++;
            if (awaited.size() == 0) begin
                note_mismatch($sformatf("result beat %0d arrived with nothing pending",
                                        results_seen));
                return;
            end
            want = awaited.pop_front();
            if (got.frame_status !== want.frame_status)
                note_mismatch($sformatf("beat %0d frame_status %0d, want %0d",
                                        results_seen, got.frame_status, want.frame_status));
            if (got.get_hit !== want.get_hit)
                note_mismatch($sformatf("beat %0d get_hit %0d, want %0d",
                                        results_seen, got.get_hit, want.get_hit));
            if (got.data_type !== want.data_type)
                note_mismatch($sformatf("beat %0d data_type %h, want %h",
                                        results_seen, got.data_type, want.data_type));
            if (got.data_x !== want.data_x)
                note_mismatch($sformatf("beat %0d data_x %0d, want %0d",
                                        results_seen, got.data_x, want.data_x));
            if (got.data_y !== want.data_y)
                note_mismatch($sformatf("beat %0d data_y %0d, want %0d",
                                        results_seen, got.data_y, want.data_y));
            if (got.reported_mode !== want.reported_mode)
                note_mismatch($sformatf("beat %0d reported_mode %0d, want %0d",
                                        results_seen, got.reported_mode, want.reported_mode));
            if (got.reported_site !== want.reported_site)
                note_mismatch($sformatf("beat %0d reported_site %0d, want %0d",
                                        results_seen, got.reported_site, want.reported_site));
            if (got.data_ready !== want.data_ready)
                note_mismatch($sformatf("beat %0d data_ready %0d, want %0d",
                                        results_seen, got.data_ready, want.data_ready));
            if (got.error_count !== want.error_count)
                note_mismatch($sformatf("beat %0d error_count %0d, want %0d",
                                        results_seen, got.error_count, want.error_count));
        endtask
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;

    link_decoder_mirror mirror;
    logic [7:0]         frame_q [$];
    int                 send_gap_max  = 0;
    int                 recv_gap_max  = 3;
    bit                 hold_off_req  = 1'b0;
    int                 items_sent    = 0;

    camera_link_frame_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_in_beat rx_beat(logic [7:0] v, logic last);
        t_in_beat b;
        b.operation  = OP_RX_BYTE;
        b.rx_byte    = v;
        b.frame_end  = last;
        b.query_mode = 3'($urandom_range(7, 0));
        return b;
    endfunction

    function automatic t_in_beat cmd_beat(logic [1:0] op, logic [2:0] mode);
        t_in_beat b;
        b.operation  = op;
        b.rx_byte    = 8'($urandom_range(255, 0));
        b.frame_end  = 1'($urandom_range(1, 0));
        b.query_mode = mode;
        return b;
    endfunction

    // Holds the beat until the block takes it; the next call either keeps
    // valid high or drops it for the drawn gap.
    task automatic send_beat(t_in_beat b);
        int gap;
        gap = $urandom_range(send_gap_max, 0);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        mirror.take_input(b);
        items_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_beat(rx_beat(frame_q[i], i == frame_q.size() - 1));
    endtask

    task automatic queue_byte(logic [7:0] v);
        frame_q.delete();
        frame_q.push_back(v);
    endtask

    task automatic queue_frame4(logic [7:0] t, logic [7:0] x, logic [7:0] y, bit corrupt);
        logic [7:0] sum;
        sum = t + x + y;
        if (corrupt)
            sum = sum ^ 8'($urandom_range(255, 1));
        frame_q.delete();
        frame_q.push_back(t);
        frame_q.push_back(x);
        frame_q.push_back(y);
        frame_q.push_back(sum);
    endtask

    task automatic random_item();
        int         pick;
        int         len;
        logic [7:0] t;
        pick = $urandom_range(99, 0);
        if (pick < 35) begin
            t = DT_53 + 8'($urandom_range(3, 0));
            queue_frame4(t, 8'($urandom), 8'($urandom), $urandom_range(9, 0) == 0);
            send_frame();
        end else if (pick < 45) begin
            // Mode acknowledge, sometimes out of range or with a foreign type byte.
            t = ($urandom_range(4, 0) == 0) ? 8'($urandom) : DT_MODE_ACK;
            if ($urandom_range(3, 0) == 0)
                queue_frame4(t, 8'($urandom), 8'($urandom_range(255, 0)), 1'b0);
            else
                queue_frame4(t, 8'($urandom_range(5, 0)), 8'($urandom_range(2, 0)),
                             $urandom_range(9, 0) == 0);
            send_frame();
        end else if (pick < 60) begin
            case ($urandom_range(4, 0))
                0: t = DT_51;
                1: t = DT_52;
                2: t = DT_55;
                default: t = 8'($urandom);
            endcase
            queue_byte(t);
            send_frame();
        end else if (pick < 68) begin
            len = $urandom_range(6, 0);
            len = (len < 2) ? len + 2 : len + 3;
            frame_q.delete();
            for (int i = 0; i < len; i++)
                frame_q.push_back(8'($urandom));
            if ($urandom_range(1, 0))
                frame_q[0] = DT_53 + 8'($urandom_range(3, 0));
            send_frame();
        end else if (pick < 90) begin
            if ($urandom_range(4, 0) != 0)
                send_beat(cmd_beat(OP_GET, 3'($urandom_range(4, 1))));
            else
                send_beat(cmd_beat(OP_GET, 3'($urandom_range(7, 0))));
        end else begin
            send_beat(cmd_beat($urandom_range(1, 0) ? OP_CLEAR_READY : OP_NOP,
                               3'($urandom_range(7, 0))));
        end
    endtask

    initial begin : stimulus
        int next_phase;
        bit pressure_done;
        int wait_cycles;
        mirror = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: short, long and mode-acknowledge frames, the rejects, gets in four modes.
        queue_byte(DT_51);
        send_frame();
        send_beat(cmd_beat(OP_GET, MODE_YPJ));
        queue_byte(DT_55);
        send_frame();
        send_beat(cmd_beat(OP_GET, MODE_IDLE));
        send_beat(cmd_beat(OP_GET, MODE_LZ));
        queue_frame4(DT_53, 8'h80, 8'h7F, 1'b0);
        send_frame();
        send_beat(cmd_beat(OP_GET, MODE_JT));
        queue_frame4(DT_MODE_ACK, 8'(MODE_LZ_WHITE), SITE_MAX, 1'b0);
        send_frame();
        queue_byte(8'hFF);
        send_frame();
        frame_q.delete();
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
        send_frame();
        send_beat(cmd_beat(OP_CLEAR_READY, 3'd7));
        send_beat(cmd_beat(OP_NOP, 3'd7));

        next_phase    = 0;
        pressure_done = 1'b0;
        while (items_sent < 820) begin
            if (items_sent >= next_phase) begin
                next_phase = items_sent + 60;
                if (!pressure_done && items_sent >= 400) begin
                    // Receiver holds off while the sender keeps pushing beats.
                    pressure_done = 1'b1;
                    send_gap_max  = 0;
                    hold_off_req  = 1'b1;
                end else begin
                    case ($urandom_range(3, 0))
                        0: begin send_gap_max = 0;  recv_gap_max = 0;  end
                        1: begin send_gap_max = 15; recv_gap_max = 15; end
                        2: begin send_gap_max = 3;  recv_gap_max = 0;  end
                        default: begin send_gap_max = 0; recv_gap_max = 15; end
                    endcase
                end
            end
            random_item();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        recv_gap_max = 0;
        wait_cycles  = 0;
        while (mirror.awaited.size() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (mirror.awaited.size() != 0)
            mirror.note_mismatch($sformatf("%0d result beats never arrived",
                                           mirror.awaited.size()));

        $display("covered %0d input beats and %0d result beats; frames accepted %0d, rejected %0d",
                 items_sent, mirror.results_seen, mirror.frames_ok, mirror.frames_bad);
        $display("gets with a hit %0d, mismatches %0d", mirror.hits, mirror.mismatches);
        if (mirror.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin : result_drain
        int stall_cycles;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_cycles = 80;
            end else begin
                stall_cycles = $urandom_range(recv_gap_max, 0);
            end
            repeat (stall_cycles) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            mirror.compare_output(o_out_data);
    end

    initial begin : watchdog
        #2000000;
        $display("run did not finish in time");
        $display("TB_ERROR");
        $finish;
    end

endmodule
